>>> sv/osnq_pkg.sv
package osnq_pkg;

   // Command codes carried in the request.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // Status codes returned in the response.
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_DUP    = 3'd2;
   localparam logic [2:0] ST_ABSENT = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;

   typedef struct packed {
      logic [1:0]          cmd;
      logic signed [31:0]  key_value;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [1:0]          match_count;
      logic signed [31:0]  first_value;
      logic signed [31:0]  second_value;
   } rsp_type;

   // What one cell shows to its neighbors.
   typedef struct packed {
      logic signed [31:0]  value;
      logic                valid;
      logic                lt;
   } link_type;

   // Commit controls broadcast to every cell.
   typedef struct packed {
      logic                insert_en;
      logic                delete_en;
      logic signed [31:0]  key;
   } cell_ctl_type;

endpackage

>>> sv/osnq_cell.sv
module osnq_cell
   import osnq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               sample,
   input  logic signed [31:0] sample_key,
   input  cell_ctl_type       ctl,
   input  link_type           left,
   input  link_type           right,
   output link_type           self_link,
   output logic               pred_sel,
   output logic               succ_sel
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               lt_ff, lt_in;

   // Compare on transfer, then shift toward or away from the insertion point on commit.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      lt_in    = lt_ff;
      if (sample) begin
         lt_in = valid_ff && (value_ff < sample_key);
      end
      if (ctl.insert_en && !lt_ff) begin
         if (left.lt) begin
            value_in = ctl.key;
            valid_in = 1'b1;
         end else begin
            value_in = left.value;
            valid_in = left.valid;
         end
      end else if (ctl.delete_en && !lt_ff) begin
         value_in = right.value;
         valid_in = right.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         lt_ff    <= lt_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // The predecessor is the last cell below the key; the successor is the first one not below.
   assign self_link = '{value: value_ff, valid: valid_ff, lt: lt_ff};
   assign pred_sel  = lt_ff && !right.lt;
   assign succ_sel  = valid_ff && !lt_ff && left.lt;

endmodule

>>> sv/osnq_nearest.sv
module osnq_nearest
   import osnq_pkg::*;
#(
   parameter int N = 64
)
(
   input  logic [N-1:0]       pred_sel,
   input  logic [N-1:0]       succ_sel,
   input  logic signed [31:0] values [N],
   input  logic [1:0]         cmd,
   input  logic signed [31:0] key,
   input  logic               empty,
   input  logic               full,
   output logic               hit,
   output rsp_type            rsp
);

   logic signed [31:0] pred_val, succ_val;
   logic               has_pred, has_succ;
   logic signed [32:0] dist_pred, dist_succ;

   // One-hot selection of the neighbors around the key.
   always_comb begin
      pred_val = '0;
      succ_val = '0;
      for (int i = 0; i < N; i++) begin
         pred_val = pred_val | (values[i] & {32{pred_sel[i]}});
         succ_val = succ_val | (values[i] & {32{succ_sel[i]}});
      end
   end

   assign has_pred  = |pred_sel;
   assign has_succ  = |succ_sel;
   assign hit       = has_succ && (succ_val == key);
   assign dist_pred = {key[31], key} - {pred_val[31], pred_val};
   assign dist_succ = {succ_val[31], succ_val} - {key[31], key};

   // Decide the response for the command.
   always_comb begin
      rsp = '0;
      case (cmd)
         CMD_INSERT: begin
            if (hit) begin
               rsp.status = ST_DUP;
            end else if (full) begin
               rsp.status = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (!hit) begin
               rsp.status = ST_ABSENT;
            end
         end
         CMD_QUERY: begin
            if (empty) begin
               rsp.status = ST_EMPTY;
            end else if (hit) begin
               rsp.match_count = 2'd1;
               rsp.first_value = key;
            end else if (has_pred && has_succ) begin
               if (dist_pred < dist_succ) begin
                  rsp.match_count = 2'd1;
                  rsp.first_value = pred_val;
               end else if (dist_succ < dist_pred) begin
                  rsp.match_count = 2'd1;
                  rsp.first_value = succ_val;
               end else begin
                  rsp.match_count  = 2'd2;
                  rsp.first_value  = pred_val;
                  rsp.second_value = succ_val;
               end
            end else if (has_pred) begin
               rsp.match_count = 2'd1;
               rsp.first_value = pred_val;
            end else begin
               rsp.match_count = 2'd1;
               rsp.first_value = succ_val;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/ordered_set_nearest_query.sv
// A request transferred at a rising edge is captured and busy rises; the response is
// registered when the commit phase ends. rsp_strobe is high for exactly one cycle and the
// receiver cannot stall it. A new request is not taken while busy is high. Every cell
// compares its value with the key at the transfer edge, and the cell row shifts and the
// neighbor selection resolves in the commit cycle, during which busy is high.
// Reset clears the set, the entry count and all control state.
module ordered_set_nearest_query
   import osnq_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic               busy_ff;
   logic [1:0]         cmd_ff;
   logic signed [31:0] key_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               hit;
   logic               empty, full;
   cell_ctl_type       ctl;

   link_type           links [CAPACITY];
   logic [CAPACITY-1:0] pred_sel, succ_sel, valid_vec;
   logic signed [31:0] cell_value [CAPACITY];

   assign accept = start && !busy_ff;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(CAPACITY));

   // Row of cells, each linked to its two neighbors.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      link_type left_link, right_link;
      if (g == 0) begin : g_first
         assign left_link = '{value: '0, valid: 1'b1, lt: 1'b1};
      end else begin : g_mid_left
         assign left_link = links[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_link = '{value: '0, valid: 1'b0, lt: 1'b0};
      end else begin : g_mid_right
         assign right_link = links[g+1];
      end
      osnq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .sample     (accept),
         .sample_key (req_data.key_value),
         .ctl        (ctl),
         .left       (left_link),
         .right      (right_link),
         .self_link  (links[g]),
         .pred_sel   (pred_sel[g]),
         .succ_sel   (succ_sel[g])
      );
      assign cell_value[g] = links[g].value;
      assign valid_vec[g]  = links[g].valid;
   end

   osnq_nearest #(.N(CAPACITY)) u_nearest (
      .pred_sel (pred_sel),
      .succ_sel (succ_sel),
      .values   (cell_value),
      .cmd      (cmd_ff),
      .key      (key_ff),
      .empty    (empty),
      .full     (full),
      .hit      (hit),
      .rsp      (rsp_in)
   );

   // Commit controls for the cell row during the busy cycle.
   always_comb begin
      ctl.key       = key_ff;
      ctl.insert_en = busy_ff && (cmd_ff == CMD_INSERT) && !hit && !full;
      ctl.delete_en = busy_ff && (cmd_ff == CMD_DELETE) && hit;
      count_in      = count_ff;
      if (ctl.insert_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.delete_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= accept;
         count_ff      <= count_in;
         rsp_strobe_ff <= busy_ff;
      end
   end

   // Request capture and response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data.cmd;
         key_ff <= req_data.key_value;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // The commit phase lasts a single cycle.
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held for more than one cycle");

   // The valid cells always form exactly the counted entries.
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("entry count disagrees with valid cells");

   // A successful insert grows the set by one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (cmd_ff == CMD_INSERT) && (rsp_ff.status == ST_OK)
      |-> count_ff == $past(count_ff) + 1'b1)
      else $error("successful insert did not add an entry");

   // Nothing beyond capacity is ever stored.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

endmodule
